// ===== design/assert_macros.svh =====
// assertion macros used by the scheduler top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/tcrr_pkg.sv =====
// types and constants of the two-class round-robin scheduler
`default_nettype none
package tcrr_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int QUANTUM_W = 4;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 4'd3;
  localparam logic [7:0] ID_RESET = 8'd1;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SERVE   = 1'b1;

  localparam logic CLASS_HIGH = 1'b0;
  localparam logic CLASS_LOW  = 1'b1;

  localparam logic [1:0] STAT_ENQUEUED = 2'd0;
  localparam logic [1:0] STAT_SERVED   = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  typedef struct packed {
    logic       operation;
    logic       job_class;
    logic [7:0] burst_time;
  } tcrr_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        served_class;
    logic [7:0]  job_id;
    logic [15:0] arrival_number;
    logic [7:0]  job_burst;
    logic [15:0] slice_start;
    logic [15:0] completion_time;
    logic [7:0]  remaining_time;
  } tcrr_out_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [7:0]  burst;
    logic [7:0]  remaining;
  } tcrr_entry_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } tcrr_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } tcrr_state_t;

endpackage
`default_nettype wire

// ===== design/tcrr_ctrl.sv =====
// controller: accepts a request, then runs the execute state
`default_nettype none
module tcrr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output tcrr_pkg::tcrr_cmd_t cmd
);
  import tcrr_pkg::*;

  tcrr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = start;
      end
      ST_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/tcrr_dp.sv =====
// datapath: job queues, pointers, counters, slice arithmetic and result register
`default_nettype none
module tcrr_dp #(
  parameter int QUEUE_DEPTH = tcrr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tcrr_pkg::tcrr_cmd_t                cmd,
  input  tcrr_pkg::tcrr_in_t                 in_item,
  input  logic                               cfg_we,
  input  logic [tcrr_pkg::QUANTUM_W-1:0]     cfg_data,
  output logic                               out_valid,
  output tcrr_pkg::tcrr_out_t                out_item
);
  import tcrr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  tcrr_entry_t hi_mem [QUEUE_DEPTH];
  tcrr_entry_t lo_mem [QUEUE_DEPTH];

  logic [PTR_W-1:0] hi_head_r, hi_head_nxt, hi_tail_r, hi_tail_nxt;
  logic [PTR_W-1:0] lo_head_r, lo_head_nxt, lo_tail_r, lo_tail_nxt;
  logic [CNT_W-1:0] hi_count_r, hi_count_nxt, lo_count_r, lo_count_nxt;
  logic [7:0]       hi_id_r, hi_id_nxt, lo_id_r, lo_id_nxt;
  logic [15:0]      arrival_r, arrival_nxt;
  logic [15:0]      clock_r, clock_nxt;
  logic [QUANTUM_W-1:0] quantum_r;

  tcrr_in_t    item_r;
  logic        any_r;
  logic        sel_r;
  tcrr_entry_t rd_hi_r, rd_lo_r;
  logic        out_valid_r;
  tcrr_out_t   out_item_r;

  logic             wr_hi, wr_lo;
  logic [PTR_W-1:0] wr_ptr;
  tcrr_entry_t      wr_entry;
  tcrr_entry_t      popped;
  tcrr_out_t        res;
  logic [QUANTUM_W-1:0] q_eff;
  logic [7:0]       slice;
  logic [7:0]       rem_left;

  // queue memories, head read at accept, written at execute
  always_ff @(posedge clk) begin
    if (wr_hi) begin
      hi_mem[wr_ptr] <= wr_entry;
    end
    if (cmd.capture) begin
      rd_hi_r <= hi_mem[hi_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_lo) begin
      lo_mem[wr_ptr] <= wr_entry;
    end
    if (cmd.capture) begin
      rd_lo_r <= lo_mem[lo_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
      any_r  <= (hi_count_r != '0) || (lo_count_r != '0);
      sel_r  <= (hi_count_r == '0) ? CLASS_LOW : CLASS_HIGH;
    end
    if (cmd.execute) begin
      out_item_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_head_r   <= '0;
      hi_tail_r   <= '0;
      hi_count_r  <= '0;
      lo_head_r   <= '0;
      lo_tail_r   <= '0;
      lo_count_r  <= '0;
      hi_id_r     <= ID_RESET;
      lo_id_r     <= ID_RESET;
      arrival_r   <= '0;
      clock_r     <= '0;
      quantum_r   <= QUANTUM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      hi_head_r   <= hi_head_nxt;
      hi_tail_r   <= hi_tail_nxt;
      hi_count_r  <= hi_count_nxt;
      lo_head_r   <= lo_head_nxt;
      lo_tail_r   <= lo_tail_nxt;
      lo_count_r  <= lo_count_nxt;
      hi_id_r     <= hi_id_nxt;
      lo_id_r     <= lo_id_nxt;
      arrival_r   <= arrival_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= cmd.execute;
      if (cfg_we) begin
        quantum_r <= cfg_data;
      end
    end
  end

  // a zero quantum still serves one unit
  assign q_eff    = (quantum_r == '0) ? QUANTUM_W'(1) : quantum_r;
  assign popped   = (sel_r == CLASS_LOW) ? rd_lo_r : rd_hi_r;
  assign slice    = (popped.remaining < 8'(q_eff)) ? popped.remaining : 8'(q_eff);
  assign rem_left = popped.remaining - slice;

  always_comb begin
    hi_head_nxt  = hi_head_r;
    hi_tail_nxt  = hi_tail_r;
    hi_count_nxt = hi_count_r;
    lo_head_nxt  = lo_head_r;
    lo_tail_nxt  = lo_tail_r;
    lo_count_nxt = lo_count_r;
    hi_id_nxt    = hi_id_r;
    lo_id_nxt    = lo_id_r;
    arrival_nxt  = arrival_r;
    clock_nxt    = clock_r;
    wr_hi        = 1'b0;
    wr_lo        = 1'b0;
    wr_ptr       = '0;
    wr_entry     = '0;
    res          = '0;
    if (cmd.execute) begin
      if (item_r.operation == OP_ENQUEUE) begin
        res.served_class = item_r.job_class;
        res.job_burst    = item_r.burst_time;
        if (item_r.job_class == CLASS_LOW) begin
          if (lo_count_r == CNT_FULL) begin
            res.status = STAT_FULL;
          end else begin
            wr_lo        = 1'b1;
            wr_ptr       = lo_tail_r;
            wr_entry.id  = lo_id_r;
            lo_tail_nxt  = ptr_inc(lo_tail_r);
            lo_count_nxt = lo_count_r + 1'b1;
            lo_id_nxt    = lo_id_r + 1'b1;
          end
        end else begin
          if (hi_count_r == CNT_FULL) begin
            res.status = STAT_FULL;
          end else begin
            wr_hi        = 1'b1;
            wr_ptr       = hi_tail_r;
            wr_entry.id  = hi_id_r;
            hi_tail_nxt  = ptr_inc(hi_tail_r);
            hi_count_nxt = hi_count_r + 1'b1;
            hi_id_nxt    = hi_id_r + 1'b1;
          end
        end
        if (wr_hi || wr_lo) begin
          wr_entry.arrival   = arrival_r;
          wr_entry.burst     = item_r.burst_time;
          wr_entry.remaining = item_r.burst_time;
          arrival_nxt        = arrival_r + 1'b1;
          res.status         = STAT_ENQUEUED;
          res.job_id         = wr_entry.id;
          res.arrival_number = arrival_r;
          res.remaining_time = item_r.burst_time;
        end
      end else if (!any_r) begin
        res.status = STAT_EMPTY;
      end else begin
        clock_nxt          = clock_r + 16'(slice);
        wr_entry           = popped;
        wr_entry.remaining = rem_left;
        // unfinished job goes back to its tail, so the count nets out
        if (sel_r == CLASS_LOW) begin
          lo_head_nxt = ptr_inc(lo_head_r);
          wr_ptr      = lo_tail_r;
          if (rem_left != '0) begin
            wr_lo       = 1'b1;
            lo_tail_nxt = ptr_inc(lo_tail_r);
          end else begin
            lo_count_nxt = lo_count_r - 1'b1;
          end
        end else begin
          hi_head_nxt = ptr_inc(hi_head_r);
          wr_ptr      = hi_tail_r;
          if (rem_left != '0) begin
            wr_hi       = 1'b1;
            hi_tail_nxt = ptr_inc(hi_tail_r);
          end else begin
            hi_count_nxt = hi_count_r - 1'b1;
          end
        end
        res.status          = STAT_SERVED;
        res.served_class    = sel_r;
        res.job_id          = popped.id;
        res.arrival_number  = popped.arrival;
        res.job_burst       = popped.burst;
        res.slice_start     = clock_r;
        res.completion_time = clock_nxt;
        res.remaining_time  = rem_left;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ===== design/two_class_round_robin_scheduler_core.sv =====
// top level of the two-class round-robin scheduler
`default_nettype none
`include "assert_macros.svh"
// Each request is handled in order, as the queue memories are read synchronously:
// in the accept cycle the queue heads are read, busy is then high for one cycle
// while the queue, counters and service clock are updated, and the result is
// shown with out_valid high for exactly one cycle after that. A new request can
// be accepted in that same result cycle. The receiver cannot stall: a result
// is gone after its strobe cycle.
// The quantum register takes a write in any cycle (cfg_ready is always high);
// write it only while no request is in flight.
module two_class_round_robin_scheduler_core #(
  parameter int QUEUE_DEPTH = tcrr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  tcrr_pkg::tcrr_in_t             in_item,
  output logic                           out_valid,
  output tcrr_pkg::tcrr_out_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcrr_pkg::QUANTUM_W-1:0] cfg_data
);
  import tcrr_pkg::*;

  tcrr_cmd_t cmd;

  assign cfg_ready = 1'b1;

  tcrr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  tcrr_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted request did not set busy")
  `ASSERT_NEXT(a_busy_result, clk, rst_n, busy, out_valid && !busy, "execute cycle gave no result")
  `ASSERT_SAME(a_result_idle, clk, rst_n, out_valid, !busy, "result shown while busy")
  `ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe held two cycles")

endmodule
`default_nettype wire
